/* hw/rtl/mcoc_pkg.sv */
// Shared types and constants for the matrix chain order cost block.
package mcoc_pkg;

  localparam int MAX_MATRICES = 16;
  localparam int DIM_WIDTH    = 16;
  localparam int COST_WIDTH   = 48;
  localparam int ROOT_W       = 5;
  localparam int STATUS_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_MANY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HDR,
    ST_SPLIT,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One issue slot of the split pipeline.
  // first: split k == i, so the left sub-chain is a single matrix (cost 0).
  // last:  split k+1 == j, so the right sub-chain is a single matrix (cost 0).
  typedef struct packed {
    logic              valid;   // split evaluation
    logic              hdr;     // fetch of the interval's outer dimensions
    logic              first;
    logic              last;
    logic [ROOT_W-1:0] split;   // k+1
  } tag_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
    logic ovf;
  } pipe_stat_t;

endpackage

/* hw/rtl/matrix_chain_order_cost.sv */
// Top level: dimension load, interval sequencer, dimension and cost memories, result register.
//
//   channel   dir  fields (low bit first)                         request when
//   s_*       in   tdata: dim_value; tlast: last_dim              s_tvalid & s_tready
//   m_*       out  tdata: min_cost, root_split, saturated;        m_tvalid & m_tready
//                  tuser: status
//
// The load state takes one dimension per cycle. A chain of n matrices then runs
// the split pipeline: one header state per interval, one split state per split,
// and a drain state at each change of chain length that waits for the pipeline
// to empty, since the cost memory write of length L must land before L+1 reads it.
// Errors and single-matrix chains load the result register at the edge that
// takes the last dimension. Reset is synchronous; the memories need no
// clearing. A waiting result only holds back a last dimension, not the
// dimensions before it.
module matrix_chain_order_cost #(
  parameter int MaxMatrices = mcoc_pkg::MAX_MATRICES,
  parameter int DimWidth    = mcoc_pkg::DIM_WIDTH,
  parameter int CostWidth   = mcoc_pkg::COST_WIDTH
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  input  logic [((DimWidth+7)/8)*8-1:0]                    s_tdata,  // dim_value
  input  logic                                             s_tlast,  // last_dim
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  // min_cost, root_split, saturated
  output logic [((CostWidth+mcoc_pkg::ROOT_W+1+7)/8)*8-1:0] m_tdata,
  output logic [mcoc_pkg::STATUS_W-1:0]                    m_tuser   // status
);

  localparam int RootW     = mcoc_pkg::ROOT_W;
  localparam int OutW      = ((CostWidth + RootW + 1 + 7) / 8) * 8;
  localparam int DimDepth  = MaxMatrices + 1;
  localparam int IdxW      = $clog2(MaxMatrices + 1);
  localparam int CntW      = $clog2(MaxMatrices + 3);
  localparam int CostDepth = MaxMatrices * MaxMatrices;
  localparam int CostAddrW = $clog2(CostDepth);

  mcoc_pkg::state_t     state, state_next;
  logic [IdxW-1:0]      len_r, len_next, i_r, i_next, k_r, k_next, n_r, n_next;
  logic [IdxW-1:0]      j_idx;
  logic [CntW-1:0]      dim_count, count_next, cnt_inc;
  logic                 ovf_seen, ovf_next;
  logic [DimWidth-1:0]  dim_value;
  logic                 in_fire, out_free;

  logic [DimWidth-1:0]  dim_mem [DimDepth];
  logic [CostWidth-1:0] cost_mem [CostDepth];
  logic [IdxW-1:0]      dim_addr_a, dim_addr_b;
  logic [CostAddrW-1:0] cost_addr_a, cost_addr_b, wr_addr_issue, addr_s1;
  logic [DimWidth-1:0]  dim_rd_a, dim_rd_b;
  logic [CostWidth-1:0] cost_rd_a, cost_rd_b;

  mcoc_pkg::tag_t       tag_issue, tag_s1;
  mcoc_pkg::pipe_stat_t pstat;
  logic [CostAddrW-1:0] wr_addr;
  logic [CostWidth-1:0] wr_cost, res_cost;
  logic [RootW-1:0]     wr_split, res_split;

  logic                 load_out, load_sat;
  logic [CostWidth-1:0] load_cost;
  logic [RootW-1:0]     load_split;
  mcoc_pkg::status_t    load_status;
  logic [CostWidth-1:0] out_cost;
  logic [RootW-1:0]     out_split;
  logic                 out_sat;
  mcoc_pkg::status_t    out_status;

  assign dim_value = s_tdata[DimWidth-1:0];
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign j_idx     = i_r + len_r - 1'b1;
  assign cnt_inc   = (dim_count < CntW'(DimDepth + 1)) ? dim_count + 1'b1 : dim_count;

  // interval (i, j), split k: dims i, k+1, j+1; costs (i,k) and (k+1,j)
  assign dim_addr_a    = (state == mcoc_pkg::ST_HDR) ? i_r : k_r + 1'b1;
  assign dim_addr_b    = j_idx + 1'b1;
  assign cost_addr_a   = CostAddrW'(i_r) * CostAddrW'(MaxMatrices) + CostAddrW'(k_r);
  assign cost_addr_b   = CostAddrW'(k_r + 1'b1) * CostAddrW'(MaxMatrices) + CostAddrW'(j_idx);
  assign wr_addr_issue = CostAddrW'(i_r) * CostAddrW'(MaxMatrices) + CostAddrW'(j_idx);

  always_comb begin
    state_next  = state;
    len_next    = len_r;
    i_next      = i_r;
    k_next      = k_r;
    n_next      = n_r;
    count_next  = dim_count;
    ovf_next    = ovf_seen || pstat.ovf;
    s_tready    = 1'b0;
    tag_issue   = '0;
    load_out    = 1'b0;
    load_cost   = '0;
    load_split  = '0;
    load_sat    = 1'b0;
    load_status = mcoc_pkg::STATUS_OK;
    unique case (state)
      mcoc_pkg::ST_LOAD: begin
        s_tready = !s_tlast || out_free;
        if (in_fire) begin
          count_next = cnt_inc;
          if (s_tlast) begin
            count_next = '0;
            if (cnt_inc < CntW'(2)) begin
              load_out    = 1'b1;
              load_status = mcoc_pkg::STATUS_FEW;
            end else if (cnt_inc > CntW'(DimDepth)) begin
              load_out    = 1'b1;
              load_status = mcoc_pkg::STATUS_MANY;
            end else if (cnt_inc == CntW'(2)) begin
              load_out = 1'b1;
            end else begin
              n_next     = IdxW'(cnt_inc - 1'b1);
              len_next   = IdxW'(2);
              i_next     = '0;
              ovf_next   = 1'b0;
              state_next = mcoc_pkg::ST_HDR;
            end
          end
        end
      end
      mcoc_pkg::ST_HDR: begin
        tag_issue.hdr = 1'b1;
        k_next        = i_r;
        state_next    = mcoc_pkg::ST_SPLIT;
      end
      mcoc_pkg::ST_SPLIT: begin
        tag_issue.valid = 1'b1;
        tag_issue.first = (k_r == i_r);
        tag_issue.last  = (k_r + 1'b1 == j_idx);
        tag_issue.split = RootW'(k_r + 1'b1);
        if (k_r + 1'b1 == j_idx) begin
          if (i_r + len_r == n_r) begin
            state_next = mcoc_pkg::ST_DRAIN;
          end else begin
            i_next     = i_r + 1'b1;
            state_next = mcoc_pkg::ST_HDR;
          end
        end else begin
          k_next = k_r + 1'b1;
        end
      end
      mcoc_pkg::ST_DRAIN: begin
        if (!tag_s1.valid && !pstat.busy) begin
          if (len_r == n_r) begin
            state_next = mcoc_pkg::ST_FINISH;
          end else begin
            len_next   = len_r + 1'b1;
            i_next     = '0;
            state_next = mcoc_pkg::ST_HDR;
          end
        end
      end
      mcoc_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_cost  = res_cost;
          load_split = res_split;
          load_sat   = ovf_seen;
          ovf_next   = 1'b0;
          state_next = mcoc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mcoc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcoc_pkg::ST_LOAD;
      dim_count <= '0;
      ovf_seen  <= 1'b0;
      m_tvalid  <= 1'b0;
      tag_s1    <= '0;
    end else begin
      state     <= state_next;
      dim_count <= count_next;
      ovf_seen  <= ovf_next;
      tag_s1    <= tag_issue;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_next;
    i_r     <= i_next;
    k_r     <= k_next;
    n_r     <= n_next;
    addr_s1 <= wr_addr_issue;
    if (pstat.wr_en) begin
      res_cost  <= wr_cost;
      res_split <= wr_split;
    end
    if (load_out) begin
      out_cost   <= load_cost;
      out_split  <= load_split;
      out_sat    <= load_sat;
      out_status <= load_status;
    end
  end

  // dimension store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (in_fire && (dim_count < CntW'(DimDepth))) begin
      dim_mem[dim_count[IdxW-1:0]] <= dim_value;
    end
    dim_rd_a <= dim_mem[dim_addr_a];
    dim_rd_b <= dim_mem[dim_addr_b];
  end

  // interval cost table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pstat.wr_en) begin
      cost_mem[wr_addr] <= wr_cost;
    end
    cost_rd_a <= cost_mem[cost_addr_a];
    cost_rd_b <= cost_mem[cost_addr_b];
  end

  mcoc_split_pipe #(
    .DimWidth  (DimWidth),
    .CostWidth (CostWidth),
    .CostAddrW (CostAddrW)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag_s1),
    .wr_addr_in (addr_s1),
    .dim_a      (dim_rd_a),
    .dim_b      (dim_rd_b),
    .cost_a     (cost_rd_a),
    .cost_b     (cost_rd_b),
    .stat       (pstat),
    .wr_addr    (wr_addr),
    .wr_cost    (wr_cost),
    .wr_split   (wr_split)
  );

  assign m_tdata = OutW'({out_sat, out_split, out_cost});
  assign m_tuser = out_status;

endmodule

/* hw/rtl/mcoc_split_pipe.sv */
// Split evaluation pipeline: saturating cost per split, running minimum per interval.
module mcoc_split_pipe #(
  parameter int DimWidth  = mcoc_pkg::DIM_WIDTH,
  parameter int CostWidth = mcoc_pkg::COST_WIDTH,
  parameter int CostAddrW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mcoc_pkg::tag_t                tag,
  input  logic [CostAddrW-1:0]          wr_addr_in,
  input  logic [DimWidth-1:0]           dim_a,
  input  logic [DimWidth-1:0]           dim_b,
  input  logic [CostWidth-1:0]          cost_a,
  input  logic [CostWidth-1:0]          cost_b,
  output mcoc_pkg::pipe_stat_t          stat,
  output logic [CostAddrW-1:0]          wr_addr,
  output logic [CostWidth-1:0]          wr_cost,
  output logic [mcoc_pkg::ROOT_W-1:0]   wr_split
);

  localparam int RootW = mcoc_pkg::ROOT_W;
  localparam int ProdW = 2 * DimWidth;
  localparam int P3W   = 3 * DimWidth;
  localparam int SumW  = CostWidth + 1;
  localparam int QCmpW = (ProdW > CostWidth) ? ProdW : CostWidth;
  localparam int TotW  = ((SumW > P3W) ? SumW : P3W) + 1;
  localparam logic [CostWidth-1:0] CostMax = {CostWidth{1'b1}};

  mcoc_pkg::tag_t s2_tag, s3_tag, s4_tag;

  logic [DimWidth-1:0]  dim_i, dim_j;
  logic [CostWidth-1:0] c_left, c_right;
  logic [ProdW-1:0]     s2_q;
  logic [SumW-1:0]      s2_sum, s3_sum;
  logic [P3W-1:0]       s3_p;
  logic                 s3_ov1;
  logic [TotW-1:0]      s3_total;
  logic                 s3_ovf;
  logic [CostWidth-1:0] s4_cost;
  logic                 s4_ov;
  logic [CostAddrW-1:0] s2_addr, s3_addr, s4_addr;
  logic [CostWidth-1:0] best_cost, best_next;
  logic [RootW-1:0]     best_split, split_next;
  logic                 upd;

  // single-matrix sub-chains cost nothing
  assign c_left  = tag.first ? '0 : cost_a;
  assign c_right = tag.last  ? '0 : cost_b;

  assign s3_total = TotW'(s3_sum) + TotW'(s3_p);
  assign s3_ovf   = s3_ov1 || (s3_total > TotW'(CostMax));

  // strict less-than keeps the smallest split on ties
  assign upd        = s4_tag.first || (s4_cost < best_cost);
  assign best_next  = upd ? s4_cost : best_cost;
  assign split_next = upd ? s4_tag.split : best_split;

  assign stat.busy  = s2_tag.valid || s3_tag.valid || s4_tag.valid;
  assign stat.wr_en = s4_tag.valid && s4_tag.last;
  assign stat.ovf   = s4_tag.valid && s4_ov;
  assign wr_addr    = s4_addr;
  assign wr_cost    = best_next;
  assign wr_split   = split_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
      s3_tag <= '0;
      s4_tag <= '0;
    end else begin
      s2_tag <= tag;
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.hdr) begin
      dim_i <= dim_a;
      dim_j <= dim_b;
    end
    s2_q    <= ProdW'(dim_i) * ProdW'(dim_a);
    s2_sum  <= SumW'(c_left) + SumW'(c_right);
    s2_addr <= wr_addr_in;
    s3_p    <= P3W'(s2_q) * P3W'(dim_j);
    s3_ov1  <= QCmpW'(s2_q) > QCmpW'(CostMax);
    s3_sum  <= s2_sum;
    s3_addr <= s2_addr;
    // a clamped first product times a zero dimension adds nothing, but still flags
    s4_cost <= (s3_total > TotW'(CostMax)) ? CostMax : s3_total[CostWidth-1:0];
    s4_ov   <= s3_ovf;
    s4_addr <= s3_addr;
    if (s4_tag.valid) begin
      best_cost  <= best_next;
      best_split <= split_next;
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for matrix_chain_order_cost: chain stimulus, DP cost predictor, result checks.
`timescale 1ns / 100ps

module tb_top;

  localparam int DIM_SLOTS   = mcoc_pkg::MAX_MATRICES + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned COST_CEIL = (64'd1 << mcoc_pkg::COST_WIDTH) - 64'd1;

  typedef struct packed {
    logic [mcoc_pkg::COST_WIDTH-1:0] cost;
    logic [mcoc_pkg::ROOT_W-1:0]     root;
    logic                            sat;
    mcoc_pkg::status_t               status;
  } chain_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // dim_value
  logic        s_tlast = 1'b0;   // last_dim
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;          // min_cost, root_split, saturated
  logic [1:0]  m_tuser;          // status

  // predictor state
  logic [mcoc_pkg::DIM_WIDTH-1:0] chain_dims [DIM_SLOTS];
  int unsigned                    dims_seen = 0;
  chain_answer_t                  pending_answers [$];

  int  errors = 0;
  int  dims_sent = 0;
  int  dims_taken = 0;
  int  answers_checked = 0;
  int  few_chains = 0;
  int  many_chains = 0;
  int  clamped_chains = 0;
  int  full_chains = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  src_gaps = 1'b1;
  bit  sink_gaps = 1'b1;

  matrix_chain_order_cost DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic longint unsigned mul_clamp(longint unsigned a, longint unsigned b,
                                                 inout bit ovf);
    if (a != 0 && b > COST_CEIL / a) begin
      ovf = 1'b1;
      return COST_CEIL;
    end
    return a * b;
  endfunction

  function automatic longint unsigned add_clamp(longint unsigned a, longint unsigned b,
                                                 inout bit ovf);
    if (a > COST_CEIL || b > COST_CEIL - a) begin
      ovf = 1'b1;
      return COST_CEIL;
    end
    return a + b;
  endfunction

  // Bottom-up interval DP over n matrices held in chain_dims.
  function automatic chain_answer_t solve_chain(int n);
    longint unsigned cost_tab [mcoc_pkg::MAX_MATRICES][mcoc_pkg::MAX_MATRICES];
    int              split_tab [mcoc_pkg::MAX_MATRICES][mcoc_pkg::MAX_MATRICES];
    longint unsigned best, prod, total;
    int              best_k, j;
    bit              have, ovf;
    chain_answer_t   ans;
    ovf = 1'b0;
    for (int i = 0; i < n; i++) begin
      cost_tab[i][i] = 0;
      split_tab[i][i] = 0;
    end
    for (int len = 2; len <= n; len++) begin
      for (int i = 0; i + len <= n; i++) begin
        j = i + len - 1;
        have = 1'b0;
        best = 0;
        best_k = 0;
        for (int k = i; k < j; k++) begin
          prod  = mul_clamp(mul_clamp(64'(chain_dims[i]), 64'(chain_dims[k+1]), ovf),
                            64'(chain_dims[j+1]), ovf);
          total = add_clamp(add_clamp(cost_tab[i][k], cost_tab[k+1][j], ovf), prod, ovf);
          // strict compare: the lowest split wins a tie
          if (!have || total < best) begin
            have = 1'b1;
            best = total;
            best_k = k + 1;
          end
        end
        cost_tab[i][j] = best;
        split_tab[i][j] = best_k;
      end
    end
    ans.cost   = cost_tab[0][n-1][mcoc_pkg::COST_WIDTH-1:0];
    ans.root   = (n > 1) ? split_tab[0][n-1][mcoc_pkg::ROOT_W-1:0] : '0;
    ans.sat    = ovf;
    ans.status = mcoc_pkg::STATUS_OK;
    return ans;
  endfunction

  // Request monitor: predicts on input acceptance, then checks output acceptance.
  always @(posedge clk) begin : monitor
    chain_answer_t ans;
    chain_answer_t exp_ans;
    if (!rst && s_tvalid && s_tready) begin
      dims_taken++;
      if (dims_seen < DIM_SLOTS) chain_dims[dims_seen] = s_tdata[mcoc_pkg::DIM_WIDTH-1:0];
      if (dims_seen < DIM_SLOTS + 1) dims_seen++;
      if (s_tlast) begin
        ans = '0;
        if (dims_seen < 2) begin
          ans.status = mcoc_pkg::STATUS_FEW;
          few_chains++;
        end else if (dims_seen > DIM_SLOTS) begin
          ans.status = mcoc_pkg::STATUS_MANY;
          many_chains++;
        end else begin
          ans = solve_chain(dims_seen - 1);
          if (ans.sat) clamped_chains++;
          if (dims_seen == DIM_SLOTS) full_chains++;
        end
        pending_answers.push_back(ans);
        dims_seen = 0;
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result cost %0d split %0d sat %0d status %0d", $time,
                 m_tdata[47:0], m_tdata[52:48], m_tdata[53], m_tuser);
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        answers_checked++;
        if (m_tdata[47:0] !== exp_ans.cost) begin
          $display("%0t: min_cost expected %0d actual %0d", $time, exp_ans.cost, m_tdata[47:0]);
          errors++;
        end
        if (m_tdata[52:48] !== exp_ans.root) begin
          $display("%0t: root_split expected %0d actual %0d", $time, exp_ans.root,
                   m_tdata[52:48]);
          errors++;
        end
        if (m_tdata[53] !== exp_ans.sat) begin
          $display("%0t: saturated expected %0d actual %0d", $time, exp_ans.sat, m_tdata[53]);
          errors++;
        end
        if (m_tuser !== exp_ans.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // Result sink: random stall bursts, plus a long hold requested by a test.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_answers.size());
    $display("matrix_chain_order_cost regression: fail");
    $finish;
  end

  // valid stays high between back-to-back requests; it only drops for a gap
  task automatic send_dim(input logic [15:0] value, input logic last);
    int gap;
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dims_sent++;
  endtask

  task automatic send_chain(input logic [15:0] dims [$]);
    foreach (dims[i]) send_dim(dims[i], i == dims.size() - 1);
  endtask

  task automatic quiet_source();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  // drop valid first so the last request is not taken again while waiting
  task automatic wait_drained();
    quiet_source();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_chain();
    logic [15:0] dims [$];
    int          count, pick, mode;
    pick = $urandom_range(0, 99);
    if (pick < 4)       count = 1;
    else if (pick < 8)  count = $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 5);
    else if (pick < 20) count = $urandom_range(9, DIM_SLOTS);
    else                count = $urandom_range(2, 8);
    mode = $urandom_range(0, 9);
    repeat (count) begin
      case (mode)
        0, 1, 2: dims.push_back(16'($urandom_range(0, 65535)));
        3, 4, 5, 6: dims.push_back(16'($urandom_range(1, 255)));
        7, 8: dims.push_back(16'($urandom_range(1, 4095)));
        default: dims.push_back(($urandom_range(0, 3) == 0) ? 16'd0 :
                                16'($urandom_range(1, 63)));
      endcase
    end
    send_chain(dims);
  endtask

  task automatic test_directed();
    send_chain('{16'd123});                                    // too few dimensions
    send_chain('{16'd65535, 16'd65535});                       // single matrix
    send_chain('{16'd65535, 16'd65535, 16'd65535});            // largest unclamped product
    send_chain('{16'd65535, 16'd65535, 16'd65535, 16'd65535}); // sum clamps
    send_chain('{16'd0, 16'd5, 16'd7});                        // zero dimension
    send_chain('{16'd4, 16'd4, 16'd4, 16'd4});                 // all splits tie
    send_chain('{16'd1, 16'd1, 16'd1});
    wait_drained();
  endtask

  task automatic test_chain_limits();
    logic [15:0] dims [$];
    repeat (DIM_SLOTS) dims.push_back(16'($urandom_range(1, 1000)));
    send_chain(dims);                                          // longest legal chain
    dims.push_back(16'($urandom_range(1, 1000)));
    send_chain(dims);                                          // one dimension too many
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (6) send_chain('{16'($urandom_range(1, 255)), 16'($urandom_range(1, 255)),
                            16'($urandom_range(1, 255))});
    wait_drained();
    // sender pauses for the answer of each chain before the next one
    repeat (4) begin
      send_random_chain();
      quiet_source();
      wait_drained();
    end
  endtask

  task automatic test_random(input int dim_budget);
    int stop_at;
    stop_at = dims_sent + dim_budget;
    while (dims_sent < stop_at) send_random_chain();
  endtask

  task automatic test_no_idle(input int dim_budget);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random(dim_budget);
  endtask

  initial begin : main
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_chain_limits();
    test_backpressure();
    test_random(900);
    test_no_idle(150);
    quiet_source();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("%0d dimensions sent, %0d chain results checked (%0d short, %0d overlong,",
             dims_taken, answers_checked, few_chains, many_chains);
    $display("  %0d clamped, %0d at full 16-matrix length), %0d cycles, %0d errors",
             clamped_chains, full_chains, cycle_count, errors);
    if (errors == 0 && pending_answers.size() == 0)
      $display("matrix_chain_order_cost regression: pass");
    else
      $display("matrix_chain_order_cost regression: fail");
    $finish;
  end

endmodule

/* matrix_chain_order_cost.f */
hw/rtl/mcoc_pkg.sv
hw/rtl/mcoc_split_pipe.sv
hw/rtl/matrix_chain_order_cost.sv
bench/tb_top.sv
